### rtl/bscf_pkg.sv
// Package for the bitmap set/clear/find-first block.
// Holds the transaction types, command and status codes, and register indexes.
// Depends on nothing.
package bscf_pkg;

    localparam int FIELD_W     = 16;
    localparam int SPAN_W      = 17;
    localparam int COUNT_OUT_W = 13;

    typedef enum logic [2:0] {
        CMD_GET         = 3'd0,
        CMD_SET         = 3'd1,
        CMD_CLEAR       = 3'd2,
        CMD_FIRST_SET   = 3'd3,
        CMD_FIRST_CLEAR = 3'd4,
        CMD_FILL        = 3'd5
    } t_cmd;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_INVAL  = 2'd1;
    localparam logic [1:0] STAT_NODATA = 2'd2;

    localparam logic [1:0] REG_LOW_BIT   = 2'd0;
    localparam logic [1:0] REG_HIGH_BIT  = 2'd1;
    localparam logic [1:0] REG_FILL_ONES = 2'd2;

    typedef struct packed {
        logic [2:0]         command;
        logic [FIELD_W-1:0] bit_index;
    } t_in_item;

    typedef struct packed {
        logic [1:0]             status;
        logic                   bit_value;
        logic [FIELD_W-1:0]     found_bit;
        logic [COUNT_OUT_W-1:0] set_count;
    } t_out_item;

    typedef enum logic [1:0] {
        WU_KEEP,
        WU_SET,
        WU_CLEAR,
        WU_FILL
    } t_wu_op;

    typedef struct packed {
        t_wu_op op;
        logic   invert;
        logic   fill_ones;
    } t_wu_ctrl;

endpackage

### rtl/bitmap_set_clear_find_first.sv
// Bitmap over bit numbers low_bit..high_bit with a running count of set bits. One transaction
// is taken at a time. For get, set and clear, a reciprocal multiply and correction find the
// word, then one read-modify-write of the word store. First_set and first_clear read and check
// one stored word at a time, since the shared word unit looks at one stored word per read. Fill
// writes every stored word (NUM_BITS/WORD_BITS rounded up), one write each. A bit number out of
// range or an unused command gets an invalid status and goes from decode to the response. After
// reset the store is swept to zero in the same way, one word a cycle, and no transaction is
// taken during that sweep. A finished result waits in the output register while the next
// transaction is accepted.
module bitmap_set_clear_find_first import bscf_pkg::*; #(
    parameter int NUM_BITS  = 4096,
    parameter int WORD_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DEPTH = (NUM_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SEL_W = $clog2(WORD_BITS);
    localparam int CW    = $clog2(NUM_BITS + 1);
    localparam int RSH   = 24;
    localparam int RECIP = (2 ** RSH) / WORD_BITS;
    localparam int PW    = FIELD_W + RSH;
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIV,
        ST_ADDR,
        ST_RMW,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_FILL,
        ST_RESP
    } t_state;

    t_state               r_state;
    logic                 r_clearing;
    logic [2:0]           r_cmd;
    logic [FIELD_W-1:0]   r_bn;
    logic [FIELD_W-1:0]   r_p;
    logic [FIELD_W-1:0]   r_q;
    logic [AW-1:0]        r_idx;
    logic [SEL_W-1:0]     r_s;
    logic [SPAN_W-1:0]    r_base;
    logic [CW-1:0]        r_count;
    logic [1:0]           r_status;
    logic                 r_bitv;
    logic [FIELD_W-1:0]   r_found;
    logic                 r_o_valid;
    t_out_item            r_out;

    logic [FIELD_W-1:0]   r_low_bit;
    logic [FIELD_W-1:0]   r_high_bit;
    logic                 r_fill_ones;

    logic [SPAN_W-1:0]    diff;
    logic [SPAN_W-1:0]    span;
    logic [FIELD_W-1:0]   p_calc;
    logic                 inval;
    logic [PW-1:0]        prod;
    logic [23:0]          rem;
    logic                 rem_fix;
    logic [23:0]          sel_full;
    logic [FIELD_W-1:0]   w_full;
    logic [AW-1:0]        w_calc;
    logic [SEL_W-1:0]     s_calc;
    logic [SPAN_W-1:0]    limit;
    logic [SPAN_W-1:0]    found_sum;
    logic [CW+COUNT_OUT_W-1:0] count_ext;
    logic                 out_free;
    logic                 cfg_wr;

    t_wu_ctrl             wu_ctrl;
    logic [WORD_BITS-1:0] wu_data;
    logic                 wu_cur;
    logic                 wu_hit;
    logic [SEL_W-1:0]     wu_index;

    logic                 mem_wr_en;
    logic                 mem_rd_en;
    logic [AW-1:0]        mem_rd_addr;
    logic [WORD_BITS-1:0] mem_rd_data;

    // Configuration registers.
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_bit   <= '0;
            r_high_bit  <= FIELD_W'(4095);
            r_fill_ones <= 1'b0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_LOW_BIT:   r_low_bit   <= pwdata[FIELD_W-1:0];
                REG_HIGH_BIT:  r_high_bit  <= pwdata[FIELD_W-1:0];
                REG_FILL_ONES: r_fill_ones <= pwdata[0];
                default:       ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_LOW_BIT:   prdata = 32'(r_low_bit);
            REG_HIGH_BIT:  prdata = 32'(r_high_bit);
            REG_FILL_ONES: prdata = 32'(r_fill_ones);
            default:       prdata = '0;
        endcase
    end

    // Span of valid bit numbers, limited to the store size.
    assign diff = SPAN_W'(r_high_bit) - SPAN_W'(r_low_bit) + SPAN_W'(1);
    always_comb begin
        if (r_high_bit < r_low_bit) begin
            span = '0;
        end else if (diff > SPAN_W'(NUM_BITS)) begin
            span = SPAN_W'(NUM_BITS);
        end else begin
            span = diff;
        end
    end

    assign p_calc = r_bn - r_low_bit;
    assign inval  = (r_bn < r_low_bit) || (SPAN_W'(p_calc) >= span);

    // The word index is estimated by a reciprocal multiply, then corrected by one step.
    assign prod     = PW'(r_p) * PW'(RECIP);
    assign rem      = 24'(r_p) - 24'(r_q) * 24'(WORD_BITS);
    assign rem_fix  = (rem >= 24'(WORD_BITS));
    assign sel_full = rem_fix ? (rem - 24'(WORD_BITS)) : rem;
    assign w_full   = r_q + FIELD_W'(rem_fix);
    assign w_calc   = w_full[AW-1:0];
    assign s_calc   = sel_full[SEL_W-1:0];

    assign limit     = (r_base < span) ? (span - r_base) : '0;
    assign found_sum = SPAN_W'(r_low_bit) + r_base + SPAN_W'(wu_index);
    assign count_ext = (CW + COUNT_OUT_W)'(r_count);

    always_comb begin
        wu_ctrl.invert    = (r_cmd == CMD_FIRST_CLEAR);
        wu_ctrl.fill_ones = r_fill_ones && !r_clearing;
        if (r_state == ST_FILL) begin
            wu_ctrl.op = WU_FILL;
        end else if (r_cmd == CMD_SET) begin
            wu_ctrl.op = WU_SET;
        end else if (r_cmd == CMD_CLEAR) begin
            wu_ctrl.op = WU_CLEAR;
        end else begin
            wu_ctrl.op = WU_KEEP;
        end
    end

    bscf_word_unit #(
        .WORD_BITS (WORD_BITS)
    ) u_word_unit (
        .i_ctrl  (wu_ctrl),
        .i_data  (mem_rd_data),
        .i_limit (limit),
        .i_sel   (r_s),
        .o_data  (wu_data),
        .o_cur   (wu_cur),
        .o_hit   (wu_hit),
        .o_index (wu_index)
    );

    assign mem_wr_en = (r_state == ST_FILL) ||
                       ((r_state == ST_RMW) &&
                        (((r_cmd == CMD_SET) && !wu_cur) || ((r_cmd == CMD_CLEAR) && wu_cur)));
    assign mem_rd_en   = (r_state == ST_ADDR) || (r_state == ST_SCAN_RD);
    assign mem_rd_addr = (r_state == ST_ADDR) ? w_calc : r_idx;

    bscf_mem #(
        .DEPTH (DEPTH),
        .WIDTH (WORD_BITS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (r_idx),
        .i_wr_data (wu_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    assign out_free    = !r_o_valid || !i_out_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_o_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_FILL;
            r_clearing <= 1'b1;
            r_idx      <= '0;
            r_base     <= '0;
            r_count    <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            if (r_o_valid && !i_out_stall && (r_state != ST_RESP)) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd   <= i_in.command;
                        r_bn    <= i_in.bit_index;
                        r_state <= ST_DECODE;
                    end
                end
                ST_DECODE: begin
                    r_status <= STAT_OK;
                    r_bitv   <= 1'b0;
                    r_found  <= '0;
                    r_idx    <= '0;
                    r_base   <= '0;
                    r_p      <= p_calc;
                    unique case (r_cmd)
                        CMD_GET, CMD_SET, CMD_CLEAR: begin
                            if (inval) begin
                                r_status <= STAT_INVAL;
                                r_state  <= ST_RESP;
                            end else begin
                                r_state <= ST_DIV;
                            end
                        end
                        CMD_FIRST_SET, CMD_FIRST_CLEAR: r_state <= ST_SCAN_RD;
                        CMD_FILL:                       r_state <= ST_FILL;
                        default: begin
                            r_status <= STAT_INVAL;
                            r_state  <= ST_RESP;
                        end
                    endcase
                end
                ST_DIV: begin
                    r_q     <= prod[RSH +: FIELD_W];
                    r_state <= ST_ADDR;
                end
                ST_ADDR: begin
                    r_idx   <= w_calc;
                    r_s     <= s_calc;
                    r_state <= ST_RMW;
                end
                ST_RMW: begin
                    if (r_cmd == CMD_GET) begin
                        r_bitv <= wu_cur;
                    end else if ((r_cmd == CMD_SET) && !wu_cur) begin
                        r_count <= r_count + CW'(1);
                    end else if ((r_cmd == CMD_CLEAR) && wu_cur) begin
                        r_count <= r_count - CW'(1);
                    end
                    r_state <= ST_RESP;
                end
                ST_SCAN_RD: begin
                    if (r_base >= span) begin
                        r_status <= STAT_NODATA;
                        r_state  <= ST_RESP;
                    end else begin
                        r_state <= ST_SCAN_CHK;
                    end
                end
                ST_SCAN_CHK: begin
                    if (wu_hit) begin
                        r_found <= found_sum[FIELD_W-1:0];
                        r_state <= ST_RESP;
                    end else begin
                        r_idx   <= r_idx + AW'(1);
                        r_base  <= r_base + SPAN_W'(WORD_BITS);
                        r_state <= ST_SCAN_RD;
                    end
                end
                ST_FILL: begin
                    r_idx  <= r_idx + AW'(1);
                    r_base <= r_base + SPAN_W'(WORD_BITS);
                    if (r_idx == LAST_IDX) begin
                        r_count    <= wu_ctrl.fill_ones ? CW'(span) : '0;
                        r_clearing <= 1'b0;
                        r_state    <= r_clearing ? ST_IDLE : ST_RESP;
                    end
                end
                ST_RESP: begin
                    if (out_free) begin
                        r_o_valid       <= 1'b1;
                        r_out.status    <= r_status;
                        r_out.bit_value <= r_bitv;
                        r_out.found_bit <= r_found;
                        r_out.set_count <= count_ext[COUNT_OUT_W-1:0];
                        r_state         <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_accept_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("Block took a second transaction while one was in progress.");

    a_count_single_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && ($past(r_state) != ST_FILL)) |->
            ((r_count == $past(r_count)) ||
             (r_count == CW'($past(r_count) + CW'(1))) ||
             (r_count == CW'($past(r_count) - CW'(1)))))
        else $error("Set count moved by more than one outside a fill.");

    a_result_from_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_RESP))
        else $error("Result appeared without passing through the response state.");

endmodule

### rtl/bscf_mem.sv
// Word store of the bitmap: one write port and one registered read port.
// Depends on nothing.
module bscf_mem #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/bscf_word_unit.sv
// Shared word unit: span masking, lowest-match search, bit modify and fill.
// Depends on bscf_pkg.
module bscf_word_unit import bscf_pkg::*; #(
    parameter int WORD_BITS = 32,
    localparam int SEL_W = $clog2(WORD_BITS)
) (
    input  t_wu_ctrl             i_ctrl,
    input  logic [WORD_BITS-1:0] i_data,
    input  logic [SPAN_W-1:0]    i_limit,
    input  logic [SEL_W-1:0]     i_sel,
    output logic [WORD_BITS-1:0] o_data,
    output logic                 o_cur,
    output logic                 o_hit,
    output logic [SEL_W-1:0]     o_index
);

    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] masked;
    logic [WORD_BITS-1:0] lowest;
    logic [WORD_BITS-1:0] onehot;

    always_comb begin
        for (int j = 0; j < WORD_BITS; j++) begin
            mask[j] = (SPAN_W'(j) < i_limit);
        end
    end

    assign masked = (i_ctrl.invert ? ~i_data : i_data) & mask;
    assign lowest = masked & (~masked + WORD_BITS'(1));
    assign o_hit  = |masked;

    always_comb begin
        o_index = '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            if (lowest[j]) begin
                o_index = o_index | SEL_W'(j);
            end
        end
    end

    assign onehot = WORD_BITS'(1) << i_sel;
    assign o_cur  = |(i_data & onehot);

    always_comb begin
        unique case (i_ctrl.op)
            WU_SET:   o_data = i_data | onehot;
            WU_CLEAR: o_data = i_data & ~onehot;
            WU_FILL:  o_data = i_ctrl.fill_ones ? mask : '0;
            default:  o_data = i_data;
        endcase
    end

endmodule
